// File: src/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest core.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  // Initial chaining values h0..h4
  localparam chain_t IV = '{32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX = 3'd4;

  // Control from the sequencer to the schedule buffer
  typedef struct packed {
    logic       byte_en;
    logic       round_en;
    logic [7:0] data;
  } sch_ctl_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic fold;
  } rnd_ctl_t;

  function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// File: src/sha1_sched.sv
// Block buffer and message schedule: a 16-word shift line fed by bytes or rounds.
module sha1_sched import sha1_pkg::*; (
  input  logic     clk,
  input  sch_ctl_t ctl,
  output word_t    w_cur
);

  // Word 0 sits in the top 32 bits
  logic [511:0] buf_q;
  word_t        w_new;
  word_t        tmp;

  // Expansion from the fixed taps t, t+2, t+8, t+13
  always_comb begin
    tmp   = buf_q[511:480] ^ buf_q[447:416] ^ buf_q[255:224] ^ buf_q[95:64];
    w_new = {tmp[30:0], tmp[31]};
  end

  assign w_cur = buf_q[511:480];

  // Bytes enter at the bottom; rounds shift a whole word
  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      buf_q <= {buf_q[503:0], ctl.data};
    end else if (ctl.round_en) begin
      buf_q <= {buf_q[479:0], w_new};
    end
  end

endmodule

// File: src/sha1_round.sv
// Chaining words and the shared SHA-1 round unit, one round per cycle.
module sha1_round import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rnd_ctl_t   ctl,
  input  logic [6:0] rnd,
  input  word_t      w_cur,
  output chain_t     chain
);

  word_t a, b, c, d, e;
  word_t sum;

  // One round: rotl5(a) + f + e + k + w
  always_comb begin
    sum = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w_cur;
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= sum;
    end
  end

  // Chaining state, folded after each block
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      chain <= IV;
    end else if (ctl.fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

// File: src/sha1_message_digest_core.sv
// Top level of the SHA-1 digest core: sequencer, padding and digest output.
// Message bytes are taken one per cycle while in_ready is high. Every 64th
// byte starts a compression (load, 80 rounds on the shared round unit, fold),
// during which in_ready is low. An item with end_of_message set starts
// padding: one pad byte per cycle (0x80, zero fill, eight length bytes), paused
// by one or two further compressions, after which h0..h4 are offered as five
// output items; the core then takes the next message. At worst (marker at byte
// 56 of the block) an end item keeps in_ready low through the rest of the pad
// bytes, a compression, a full block of pad bytes and a second compression
// before the first digest word is offered, plus the five output handshakes.
module sha1_message_digest_core import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic [6:0]  rnd;
  logic [2:0]  out_idx;
  logic        pad_active;
  logic        marker_done;
  logic        len_ok;
  logic        final_blk;

  sch_ctl_t    sch_ctl;
  rnd_ctl_t    rnd_ctl;
  word_t       w_cur;
  chain_t      chain;
  logic [63:0] len_bits;
  logic [7:0]  pad_data;
  logic        in_acc;
  logic        out_acc;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Pad byte: marker, then zeros, then the big-endian bit length
  always_comb begin
    len_bits = {count, 3'b000};
    if (!marker_done) begin
      pad_data = PAD_MARK;
    end else if (len_ok && fill >= 6'd56) begin
      pad_data = len_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_data = 8'h00;
    end
  end

  // Submodule control
  always_comb begin
    sch_ctl.byte_en  = (in_acc && byte_present) || (state == S_PAD);
    sch_ctl.round_en = (state == S_ROUND);
    sch_ctl.data     = (state == S_PAD) ? pad_data : data_byte;
    rnd_ctl.init     = out_acc && (out_idx == LAST_IDX);
    rnd_ctl.load     = (state == S_LOAD);
    rnd_ctl.step     = (state == S_ROUND);
    rnd_ctl.fold     = (state == S_FOLD);
  end

  // Digest word select
  always_comb begin
    case (out_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = chain[0];
    endcase
  end

  assign word_index = out_idx;
  assign last_word  = (out_idx == LAST_IDX);

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (sch_ctl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rnd_ctl),
    .rnd   (rnd),
    .w_cur (w_cur),
    .chain (chain)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      count       <= '0;
      rnd         <= '0;
      out_idx     <= '0;
      pad_active  <= 1'b0;
      marker_done <= 1'b0;
      len_ok      <= 1'b0;
      final_blk   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (byte_present) begin
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
              if (fill == 6'd63) begin
                state <= S_LOAD;
              end
            end
            if (end_of_message) begin
              pad_active  <= 1'b1;
              marker_done <= 1'b0;
              len_ok      <= 1'b0;
              final_blk   <= 1'b0;
              if (!(byte_present && fill == 6'd63)) begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          fill        <= fill + 6'd1;
          marker_done <= 1'b1;
          if (fill == 6'd63) begin
            state <= S_LOAD;
            if (marker_done && len_ok) begin
              final_blk <= 1'b1;
            end else begin
              len_ok <= 1'b1;
            end
          end else if (!marker_done) begin
            // length fits behind the marker only up to byte 55
            len_ok <= (fill <= 6'd55);
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (final_blk) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_IDX) begin
              fill        <= '0;
              count       <= '0;
              pad_active  <= 1'b0;
              marker_done <= 1'b0;
              len_ok      <= 1'b0;
              final_blk   <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The end item always leads into padding or a compression
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_message) |=> !in_ready)
    else $error("input taken right after end of message");

  // Input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while digest pending");

  // Round counter stays in range
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rnd <= LAST_ROUND))
    else $error("round counter out of range");

  // Last digest word leaves a fresh, empty message
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (in_ready && fill == 6'd0 && count == 61'd0))
    else $error("state not reinitialised after digest");
`endif

endmodule

// File: tb/sha1_message_digest_core_tb.sv
// Self-checking testbench for the SHA-1 message digest core.
`timescale 1ns / 100ps

module sha1_message_digest_core_tb import sha1_pkg::*; ();

  // Chaining start values, round constants and the padding marker
  localparam word_t START_H0 = 32'h67452301;
  localparam word_t START_H1 = 32'hEFCDAB89;
  localparam word_t START_H2 = 32'h98BADCFE;
  localparam word_t START_H3 = 32'h10325476;
  localparam word_t START_H4 = 32'hC3D2E1F0;
  localparam word_t RK_CH  = 32'h5A827999;
  localparam word_t RK_PA1 = 32'h6ED9EBA1;
  localparam word_t RK_MAJ = 32'h8F1BBCDC;
  localparam word_t RK_PA2 = 32'hCA62C1D6;
  localparam logic [7:0] END_MARK = 8'h80;
  localparam int IDLE_PCT = 19;
  localparam int ITEM_TARGET = 130;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_word_t;

  // Running SHA-1 over the accepted bytes; holds the digest words still owed
  class digest_tracker;
    word_t          chain[5];
    logic [7:0]     blk[64];
    int unsigned    fill;
    logic [60:0]    byte_count;
    digest_word_t   owed[$];
    int unsigned    errors;
    int unsigned    words_seen;
    int unsigned    messages;
    int unsigned    bytes_taken;

    function new();
      restart();
      errors = 0;
      words_seen = 0;
      messages = 0;
      bytes_taken = 0;
    endfunction

    function void restart();
      chain = '{START_H0, START_H1, START_H2, START_H3, START_H4};
      fill = 0;
      byte_count = '0;
    endfunction

    function word_t rol(word_t v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    // 80 rounds over the buffered block, folded into the chain
    function void crunch_block();
      word_t w[80];
      word_t a, b, c, d, e, f, k, tmp;
      for (int t = 0; t < 16; t++) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end
      for (int t = 16; t < 80; t++) begin
        w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = RK_CH;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = RK_PA1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = RK_MAJ;
        end else begin
          f = b ^ c ^ d;
          k = RK_PA2;
        end
        tmp = rol(a, 5) + f + e + k + w[t];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // An accepted input item: absorb the byte, pad and queue the digest on end
    function void note_item(logic [7:0] data, logic present, logic eom);
      logic [63:0]  bit_len;
      digest_word_t nxt;
      if (present) begin
        blk[fill] = data;
        fill++;
        byte_count++;
        bytes_taken++;
        if (fill == 64) begin
          crunch_block();
          fill = 0;
        end
      end
      if (!eom) begin
        return;
      end
      bit_len = {byte_count, 3'b000};
      blk[fill] = END_MARK;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        crunch_block();
        fill = 0;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++) begin
        blk[56+i] = bit_len[8*(7-i) +: 8];
      end
      crunch_block();
      for (int i = 0; i < 5; i++) begin
        nxt.word = chain[i];
        nxt.idx  = 3'(i);
        nxt.last = (i == 4);
        owed.insert(owed.size(), nxt);
      end
      messages++;
      restart();
    endfunction

    // An accepted output item against the oldest owed digest word
    function void check_word(word_t word, logic [2:0] idx, logic last);
      digest_word_t exp;
      words_seen++;
      if (owed.size() == 0) begin
        $error("digest word %h (index %0d) with none outstanding", word, idx);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (word !== exp.word) begin
        $error("digest_word mismatch: expected %h, actual %h", exp.word, word);
        errors++;
      end
      if (idx !== exp.idx) begin
        $error("word_index mismatch: expected %0d, actual %0d", exp.idx, idx);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last_word mismatch: expected %0b, actual %0b", exp.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_tracker tracker = new();
  logic        calm;
  int unsigned items_sent;

  sha1_message_digest_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random back-pressure except in the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Handshake monitors feed the tracker
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      tracker.note_item(data_byte, byte_present, end_of_message);
    end
    if (!rst && out_valid && out_ready) begin
      tracker.check_word(digest_word, word_index, last_word);
    end
  end

  // One input item: optional random gap, then hold until accepted
  task automatic send_item(logic [7:0] data, logic present, logic eom);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid     <= 1'b0;
        data_byte    <= 8'($urandom);
        byte_present <= 1'($urandom);
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    data_byte      <= data;
    byte_present   <= present;
    end_of_message <= eom;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (present || eom) begin
      items_sent++;
    end
  endtask

  // A message of random bytes, ended on the last byte or by a bare end item
  task automatic send_message(int unsigned len);
    logic separate_end;
    separate_end = (len == 0) || ($urandom_range(0, 99) < 40);
    for (int unsigned i = 0; i < len; i++) begin
      // occasional idle items as noise
      if ($urandom_range(0, 99) < 8) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(8'($urandom), 1'b1, !separate_end && (i == len - 1));
    end
    if (separate_end) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Run-time limit
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned msg_no;
    int unsigned len;
    calm           <= 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    data_byte      <= 8'h00;
    byte_present   <= 1'b0;
    end_of_message <= 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle item, empty message, byte extremes, both end styles
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);

    // Random messages: mostly short, some around the padding boundaries
    msg_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (msg_no == 0) begin
        len = 56;
      end else if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(52, 66);
      end else begin
        len = $urandom_range(0, 12);
      end
      calm <= (msg_no >= 2 && msg_no <= 4);
      send_message(len);
      msg_no++;
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    // Drain, then allow for any stray late output
    while (tracker.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);

    $display("Run covered %0d messages, %0d message bytes, %0d input items.",
             tracker.messages, tracker.bytes_taken, items_sent);
    $display("Digest words checked: %0d, mismatches: %0d.",
             tracker.words_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
